/* rtl/core/dabti_pkg.sv */
// Shared types and constants for the DAB time deinterleaver.
// No dependencies; imported by every module of the block.
`default_nettype none

package dabti_pkg;

   // Width of the fragment length register
   localparam int unsigned LEN_W = 14;
   // Width of one soft sample
   localparam int unsigned SAMPLE_W = 16;
   // Frame slots per position and slot index width
   localparam int unsigned SLOTS = 16;
   localparam int unsigned SLOT_W = 4;
   // Warm-up counter saturates after this many completed frames
   localparam logic [4:0] WARMUP_DONE = 5'd16;

   // Per-item control that travels with the memory access
   typedef struct packed {
      logic last;    // last sample of the frame
      logic emit;    // item produces a result
      logic bypass;  // zero delay: result is the incoming sample
   } item_ctrl_type;

   // Frame delay indexed by position modulo 16
   function automatic logic [SLOT_W-1:0] frame_delay(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W-1:0] d;
      unique case (idx)
         4'd0:  d = 4'd15;
         4'd1:  d = 4'd7;
         4'd2:  d = 4'd11;
         4'd3:  d = 4'd3;
         4'd4:  d = 4'd13;
         4'd5:  d = 4'd5;
         4'd6:  d = 4'd9;
         4'd7:  d = 4'd1;
         4'd8:  d = 4'd14;
         4'd9:  d = 4'd6;
         4'd10: d = 4'd10;
         4'd11: d = 4'd2;
         4'd12: d = 4'd12;
         4'd13: d = 4'd4;
         4'd14: d = 4'd8;
         default: d = 4'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/dabti_addr_gen.sv */
// Position, frame slot and warm-up counters; store addresses per item.
// Depends on dabti_pkg.
`default_nettype none

module dabti_addr_gen
   import dabti_pkg::*;
#(
   parameter int unsigned MAX_FRAGMENT = 8192
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          len_we,
   input  wire logic [LEN_W-1:0]              len_data,
   output logic [$clog2(MAX_FRAGMENT)+SLOT_W-1:0] wr_addr,
   output logic [$clog2(MAX_FRAGMENT)+SLOT_W-1:0] rd_addr,
   output item_ctrl_type                      ctrl,
   output logic                               warm_done
);

   localparam int unsigned POS_W = $clog2(MAX_FRAGMENT);
   localparam int unsigned CW    = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAGMENT);

   logic [LEN_W-1:0]  len_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [4:0]        warm_ff, warm_in;

   logic [CW-1:0]     len_ext, eff_len, pos_next;
   logic [SLOT_W-1:0] delay, rd_slot;

   // Clamp the configured length to 1..MAX_FRAGMENT
   always_comb begin
      len_ext = CW'(len_ff);
      if (len_ext == '0) begin
         eff_len = CW'(1);
      end else if (len_ext > MAX_C) begin
         eff_len = MAX_C;
      end else begin
         eff_len = len_ext;
      end
   end

   // Addresses and per-item control
   always_comb begin
      pos_next    = CW'(pos_ff) + CW'(1);
      delay       = frame_delay(pos_ff[SLOT_W-1:0]);
      rd_slot     = slot_ff - delay;
      wr_addr     = {pos_ff, slot_ff};
      rd_addr     = {pos_ff, rd_slot};
      ctrl.last   = (pos_next >= eff_len);
      ctrl.emit   = warm_ff[4];
      ctrl.bypass = (delay == '0);
      warm_done   = warm_ff[4];
   end

   // Advance counters on each accepted item
   always_comb begin
      pos_in  = pos_ff;
      slot_in = slot_ff;
      warm_in = warm_ff;
      if (advance) begin
         if (ctrl.last) begin
            pos_in  = '0;
            slot_in = slot_ff + SLOT_W'(1);
            if (warm_ff != WARMUP_DONE) begin
               warm_in = warm_ff + 5'd1;
            end
         end else begin
            pos_in = pos_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= LEN_W'(1);
         pos_ff  <= '0;
         slot_ff <= '0;
         warm_ff <= '0;
      end else begin
         if (len_we) begin
            len_ff <= len_data;
         end
         pos_ff  <= pos_in;
         slot_ff <= slot_in;
         warm_ff <= warm_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dabti_delay_mem.sv */
// Delay store: one write port and one registered read port.
// Depends on dabti_pkg.
`default_nettype none

module dabti_delay_mem
   import dabti_pkg::*;
#(
   parameter int unsigned DEPTH  = 131072,
   parameter int unsigned ADDR_W = 17
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [SAMPLE_W-1:0] wr_data,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic [SAMPLE_W-1:0]      rd_data_ff
);

   logic [SAMPLE_W-1:0] mem [DEPTH];

   // Write the incoming sample
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read old data; hold output when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/dab_time_deinterleaver.sv */
// DAB time deinterleaver: frame-delay deinterleaving through one sample store.
// An accepted item passes stage 1 (store read), then the output register, before rsp_valid rises.
// Throughput: one item per cycle while the output is not stalled, set by the single write and read port of the store.
// No results for the first 16 frames after reset while the store fills.
// Reset is synchronous; counters clear at once, store contents are not cleared.
// Depends on dabti_pkg, dabti_addr_gen, dabti_delay_mem.
`default_nettype none

module dab_time_deinterleaver
   import dabti_pkg::*;
#(
   parameter int unsigned MAX_FRAGMENT = 8192
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0]      rsp_sample_out,
   output logic                            rsp_frame_last,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [LEN_W-1:0]           csr_fragment_length
);

   localparam int unsigned POS_W  = $clog2(MAX_FRAGMENT);
   localparam int unsigned ADDR_W = POS_W + SLOT_W;
   localparam int unsigned DEPTH  = MAX_FRAGMENT * SLOTS;

   logic               req_fire;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   item_ctrl_type      addr_ctrl;
   logic               warm_done;
   logic [SAMPLE_W-1:0] mem_rd_data;

   logic                s1_valid_ff, s1_valid_in;
   item_ctrl_type       s1_ctrl_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic                s1_move;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff;
   logic                rsp_last_ff;
   logic                out_free;

   assign csr_ready = 1'b1;

   // Counters and addresses
   dabti_addr_gen #(
      .MAX_FRAGMENT(MAX_FRAGMENT)
   ) u_addr_gen (
      .clock    (clock),
      .reset    (reset),
      .advance  (req_fire),
      .len_we   (csr_valid),
      .len_data (csr_fragment_length),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .ctrl     (addr_ctrl),
      .warm_done(warm_done)
   );

   // Sample store
   dabti_delay_mem #(
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_delay_mem (
      .clock     (clock),
      .wr_en     (req_fire),
      .wr_addr   (wr_addr),
      .wr_data   (req_sample_in),
      .rd_en     (req_fire),
      .rd_addr   (rd_addr),
      .rd_data_ff(mem_rd_data)
   );

   // Handshake: stage 1 drains into the output register
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      s1_move     = s1_valid_ff && out_free;
      req_ready   = !s1_valid_ff || out_free;
      req_fire    = req_valid && req_ready;
      s1_valid_in = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   end

   // Output register: load on an emitting item, drop otherwise
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_move && s1_ctrl_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage 1 payload: control and bypass sample
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ctrl_ff   <= addr_ctrl;
         s1_sample_ff <= req_sample_in;
      end
   end

   // Output payload: store read data, or the incoming sample on zero delay
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_sample_ff <= s1_ctrl_ff.bypass ? s1_sample_ff : mem_rd_data;
         rsp_last_ff   <= s1_ctrl_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_frame_last = rsp_last_ff;

   // A stalled stage 1 keeps its store read data
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(mem_rd_data)))
      else $error("stage 1 read data changed while stalled");

   // Items accepted during warm-up never produce a result
   a_warm_drop: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !addr_ctrl.emit) |=> !s1_ctrl_ff.emit)
      else $error("warm-up item marked for output");

   // Warm-up completion is permanent
   a_warm_stay: assert property (@(posedge clock) disable iff (reset)
      warm_done |=> warm_done)
      else $error("warm-up state fell back");

endmodule

`default_nettype wire

/* bench/dabti_frame_check.sv */
// Result checker for the DAB time deinterleaver: tracks accepted samples and
// length writes, predicts each delayed sample and compares it on the output.
// Depends on dabti_pkg for widths and slot counts.
`timescale 1ns / 1ps

module dabti_frame_check
   import dabti_pkg::*;
#(
   parameter int unsigned MAX_FRAGMENT = 8192
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_in,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input  wire logic                       rsp_frame_last,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic [LEN_W-1:0]           csr_fragment_length,
   output int                              failures,
   output int                              outstanding,
   output int                              frame_position,
   output int                              results_seen
);

   // Frame delay per position modulo 16, one nibble each, position 0 in the low nibble
   localparam logic [63:0] DELAY_BY_POS = 64'h084C_2A6E_195D_3B7F;
   localparam int unsigned RING_AW = $clog2(MAX_FRAGMENT * SLOTS);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } deint_result_type;

   deint_result_type     delayed_q[$];
   logic [SAMPLE_W-1:0]  frame_ring [0:MAX_FRAGMENT*SLOTS-1];
   logic [LEN_W-1:0]     length_reg;
   int unsigned          pos_count;
   logic [SLOT_W-1:0]    write_slot;
   int unsigned          filled_frames;

   // Store one sample, read the one written lag frames earlier at the same position
   task automatic deinterleave_sample(input logic [SAMPLE_W-1:0] sample);
      int unsigned   span;
      int unsigned   pos;
      int unsigned   base;
      logic [SLOT_W-1:0] lag;
      logic [SLOT_W-1:0] read_slot;
      logic [RING_AW-1:0] wr_idx;
      logic [RING_AW-1:0] rd_idx;
      logic          at_end;
      deint_result_type res;
      span = (length_reg == '0) ? 1 : length_reg;
      if (span > MAX_FRAGMENT)
         span = MAX_FRAGMENT;
      pos = (pos_count >= MAX_FRAGMENT) ? 0 : pos_count;
      lag = DELAY_BY_POS[(pos % SLOTS) * 4 +: 4];
      base = pos * SLOTS;
      wr_idx = RING_AW'(base + write_slot);
      frame_ring[wr_idx] = sample;
      read_slot = write_slot - lag;
      rd_idx = RING_AW'(base + read_slot);
      res.sample = frame_ring[rd_idx];
      at_end = (pos + 1 >= span);
      res.last = at_end;
      // advance position, wrap into the next frame slot at the end of a frame
      if (at_end) begin
         pos_count = 0;
         write_slot = write_slot + 1'b1;
      end else begin
         pos_count = pos + 1;
      end
      // drop results while the store fills
      if (filled_frames < WARMUP_DONE) begin
         if (at_end)
            filled_frames++;
      end else begin
         delayed_q.push_back(res);
      end
   endtask

   // Compare one output item against the oldest prediction
   task automatic compare_result(input logic [SAMPLE_W-1:0] sample, input logic last);
      deint_result_type want;
      if (delayed_q.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("%0t: output item 0x%04h last=%0b with no prediction pending",
                     $realtime, sample, last);
      end else begin
         want = delayed_q.pop_front();
         results_seen++;
         if (want.sample !== sample || want.last !== last) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result %0d: sample exp 0x%04h got 0x%04h, last exp %0b got %0b",
                        $realtime, results_seen, want.sample, sample, want.last, last);
         end
      end
   endtask

   // Follow the three channels; predict before comparing so same-edge order never matters
   always @(posedge clock) begin
      if (reset) begin
         delayed_q.delete();
         length_reg = LEN_W'(1);
         pos_count = 0;
         write_slot = '0;
         filled_frames = 0;
         failures = 0;
         results_seen = 0;
      end else begin
         if (req_valid && req_ready)
            deinterleave_sample(req_sample_in);
         if (rsp_valid && rsp_ready)
            compare_result(rsp_sample_out, rsp_frame_last);
         // new length takes effect from the next sample
         if (csr_valid && csr_ready)
            length_reg = csr_fragment_length;
      end
      outstanding = delayed_q.size();
      frame_position = pos_count;
   end

endmodule

/* bench/testbench.sv */
// Top of the DAB time deinterleaver bench: clock, reset, sample and length stimulus,
// output stalls and the verdict. Depends on dabti_pkg, the block and dabti_frame_check.
`timescale 1ns / 1ps

module testbench
   import dabti_pkg::*;
;

   localparam int WARM_LEN       = 48;    // frame length used while the store fills
   localparam int ITEM_TARGET    = 1950;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 6;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {
      LEN_ONE,
      LEN_ZERO,
      LEN_FULL,
      LEN_SIXTEEN,
      LEN_HUGE,
      LEN_RANDOM
   } len_pick_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample_out;
   logic                       rsp_frame_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [LEN_W-1:0]           csr_fragment_length = '0;

   int failures;
   int outstanding;
   int frame_position;
   int results_seen;

   int items_sent = 0;
   int settings_written = 0;
   int snd_idle_pct = 8;
   int rsp_idle_pct = 85;
   int stall_cycles = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;

   dab_time_deinterleaver DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_in       (req_sample_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample_out      (rsp_sample_out),
      .rsp_frame_last      (rsp_frame_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_fragment_length (csr_fragment_length)
   );

   dabti_frame_check frame_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_in       (req_sample_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_sample_out      (rsp_sample_out),
      .rsp_frame_last      (rsp_frame_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_fragment_length (csr_fragment_length),
      .failures            (failures),
      .outstanding         (outstanding),
      .frame_position      (frame_position),
      .results_seen        (results_seen)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hold reset, then release it on a falling edge
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Output side: random ready, or a long hold-off once when asked for
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Stop the run when no channel moves an item for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, outstanding);
            $display("FAIL dab_time_deinterleaver");
            $finish;
         end
      end
   end

   // Mostly random samples, with the extreme values mixed in
   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 15))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Offer one sample on the input, with random idle cycles ahead of it
   task automatic push_sample(input logic [SAMPLE_W-1:0] value);
      @(negedge clock);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < snd_idle_pct);
      end
      req_valid <= 1'b1;
      req_sample_in <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Stop offering, wait for every predicted result, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write the fragment length once the block is idle
   task automatic write_length(input logic [LEN_W-1:0] len);
      drain_results();
      csr_valid <= 1'b1;
      csr_fragment_length <= len;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_written++;
   endtask

   initial begin
      int        random_start;
      int        budget;
      int        done;
      int        round_no;
      int        n_items;
      int        span;
      bit        was_huge;
      bit        pressure_done;
      len_pick_type pick;
      logic [LEN_W-1:0] new_len;

      round_no = 0;
      was_huge = 1'b0;
      pressure_done = 1'b0;
      @(negedge reset);

      // Fill the first WARM_LEN positions of the store in all 16 slots, the position range used later
      write_length(LEN_W'(WARM_LEN));
      repeat (SLOTS * WARM_LEN) push_sample(random_sample());

      // Walking ones, then the extremes
      for (int k = 0; k < SAMPLE_W; k++)
         push_sample(16'h0001 << k);
      push_sample(16'h7FFF);
      push_sample(16'h8000);
      push_sample(16'h0000);
      push_sample(16'hFFFF);
      push_sample(16'hAAAA);
      push_sample(16'h5555);

      random_start = items_sent;
      budget = ITEM_TARGET - items_sent;
      while (items_sent < ITEM_TARGET) begin
         // Split the random part into three stall profiles
         done = items_sent - random_start;
         if (done < budget / 3) begin
            snd_idle_pct = 8;
            rsp_idle_pct = 85;
         end else if (done < 2 * budget / 3) begin
            snd_idle_pct = 85;
            rsp_idle_pct = 8;
         end else begin
            snd_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         // First rounds walk through every kind of length once
         if (round_no <= LEN_RANDOM)
            pick = len_pick_type'(round_no);
         else if ($urandom_range(0, 9) >= LEN_RANDOM)
            pick = LEN_RANDOM;
         else
            pick = len_pick_type'($urandom_range(LEN_ONE, LEN_HUGE));
         // follow an oversized length with a short one so the frame ends early
         if (was_huge && pick == LEN_HUGE)
            pick = LEN_RANDOM;
         if (snd_idle_pct == 0 && !pressure_done)
            pick = LEN_FULL;

         case (pick)
            LEN_ONE:     new_len = LEN_W'(1);
            LEN_ZERO:    new_len = '0;
            LEN_FULL:    new_len = LEN_W'(WARM_LEN);
            LEN_SIXTEEN: new_len = LEN_W'(SLOTS);
            LEN_HUGE: begin
               case ($urandom_range(0, 3))
                  0:       new_len = LEN_W'(8192);
                  1:       new_len = LEN_W'(16383);
                  2:       new_len = LEN_W'(8191);
                  default: new_len = LEN_W'($urandom_range(WARM_LEN + 1, 16383));
               endcase
            end
            default:     new_len = LEN_W'($urandom_range(2, WARM_LEN));
         endcase
         write_length(new_len);

         // Keep positions inside the filled part of the store under a huge length
         if (pick == LEN_HUGE) begin
            n_items = $urandom_range(0, WARM_LEN - 1 - frame_position);
         end else begin
            span = (new_len == 0) ? 1 : new_len;
            n_items = $urandom_range(1, 2 * span + 8);
         end

         // Hold the output off while samples keep coming, so the input backs up
         if (snd_idle_pct == 0 && !pressure_done) begin
            n_items = 3 * WARM_LEN;
            hold_request = 1'b1;
            pressure_done = 1'b1;
         end

         repeat (n_items) push_sample(random_sample());
         was_huge = (pick == LEN_HUGE);
         round_no++;
      end

      drain_results();
      $display("Sent %0d samples over %0d length settings (0, 1, 16, up to 16383);",
               items_sent, settings_written);
      $display("checked %0d delayed results under input/output stalls and a %0d-cycle hold-off.",
               results_seen, HOLD_CYCLES);
      if (failures == 0 && outstanding == 0)
         $display("PASS dab_time_deinterleaver");
      else
         $display("FAIL dab_time_deinterleaver");
      $finish;
   end

endmodule

/* dab_time_deinterleaver.f */
rtl/core/dabti_pkg.sv
rtl/core/dabti_addr_gen.sv
rtl/core/dabti_delay_mem.sv
rtl/core/dab_time_deinterleaver.sv
bench/dabti_frame_check.sv
bench/testbench.sv
